>>> rtl/core/jda_pkg.sv
// ----------------------------------------------------------------------------
// jda_pkg
// Shared types and constants of the joystick direction auto-repeat block.
// ----------------------------------------------------------------------------
package jda_pkg;

    // Input item kinds, carried on the slave tuser
    localparam logic [1:0] OP_AXIS   = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Direction codes, also the hold counter index
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Counter select of the shared unit: four hold counters, then fire
    localparam logic [2:0] SEL_FIRE  = 3'd4;

    // Configuration register indexes
    localparam logic REG_DEAD_ZONE    = 1'b0;
    localparam logic REG_REPEAT_START = 1'b1;

    // Register reset values
    localparam logic [14:0] DEAD_ZONE_RST    = 15'd4095;
    localparam logic [7:0]  REPEAT_START_RST = 8'd15;

    localparam logic [7:0]  COUNT_MAX = 8'd255;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Result of the shared count and compare unit
    typedef struct packed {
        logic [7:0] inc;      // saturating increment of the selected count
        logic       nonzero;  // selected count is not zero
        logic       emit;     // selected count produces a press this tick
        logic       below;    // axis value below minus dead zone
        logic       above;    // axis value above dead zone
    } alu_res_t;

endpackage

>>> rtl/core/jda_alu.sv
// ----------------------------------------------------------------------------
// jda_alu
// Shared count and compare unit: saturating increment, press test and
// dead zone compare for whichever counter the sequencer selects.
// ----------------------------------------------------------------------------
module jda_alu (
    input  logic [7:0]         count,
    input  logic [7:0]         repeat_start,
    input  logic [15:0]        axis_value,
    input  logic [14:0]        dead_zone,
    output jda_pkg::alu_res_t  res
);
    import jda_pkg::*;

    logic signed [16:0] value_ext;
    logic signed [16:0] dz_pos;
    logic signed [16:0] dz_neg;

    // Widen both sides of the dead zone compare to 17 bits signed
    assign value_ext = $signed({axis_value[15], axis_value});
    assign dz_pos    = $signed({2'b00, dead_zone});
    assign dz_neg    = -dz_pos;

    // Count arithmetic and compares
    always_comb
    begin
        res.inc     = (count == COUNT_MAX) ? COUNT_MAX : count + 8'd1;
        res.nonzero = (count != 8'd0);
        res.emit    = (count != 8'd0) && ((count == 8'd1) || (count >= repeat_start));
        res.below   = (value_ext < dz_neg);
        res.above   = (value_ext > dz_pos);
    end

endmodule

>>> rtl/core/joystick_direction_autorepeat_top.sv
// ----------------------------------------------------------------------------
// joystick_direction_autorepeat_top
// Joystick events in, direction presses with auto-repeat out.
// ----------------------------------------------------------------------------
// An axis or button item is accepted and then makes one update through the
// shared count unit. A frame tick is accepted, then scans the four
// directions one by one through the same unit, and then emits one press
// per cycle while the output is free, or goes back to idle from the emit
// state when there is no press. Presses of a tick leave in the order up,
// down, left, right with tlast on the final one; a tick with no press emits
// nothing. The input is not ready while an item is being worked on. The
// user must write the configuration through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module joystick_direction_autorepeat_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // axis_index[7:0], axis_value[23:8],
                                   // button_index[31:24], button_pressed[32], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // direction[1:0], zero
    output logic        m_tuser,   // fire[0]
    output logic        m_tlast
);
    import jda_pkg::*;

    state_t       state_reg, state_next;
    logic [7:0]   hold_reg [4];
    logic [7:0]   hold_next [4];
    logic [7:0]   fire_cnt_reg, fire_cnt_next;
    logic [14:0]  dead_zone_reg;
    logic [7:0]   repeat_start_reg;
    logic [1:0]   idx_reg, idx_next;
    logic [3:0]   mask_reg, mask_next;

    // latched item
    logic [1:0]   op_reg;
    logic [7:0]   axis_index_reg;
    logic [15:0]  axis_value_reg;
    logic [7:0]   button_index_reg;
    logic         button_pressed_reg;
    logic         fire_flag_reg;

    // output register
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   out_dir_reg, out_dir_next;
    logic         out_fire_reg, out_fire_next;
    logic         out_last_reg, out_last_next;

    logic [2:0]   sel;
    logic [7:0]   count_mux;
    alu_res_t     alu;
    logic [1:0]   neg_dir;
    logic [1:0]   pos_dir;
    logic         axis_ok;
    logic [1:0]   low_dir;
    logic [3:0]   mask_rest;
    logic         in_fire;
    logic         out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_dir_reg};
    assign m_tuser  = out_fire_reg;
    assign m_tlast  = out_last_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Axis to direction pair
    assign axis_ok = (axis_index_reg == 8'd0) || (axis_index_reg == 8'd1);
    assign neg_dir = (axis_index_reg == 8'd0) ? DIR_LEFT : DIR_UP;
    assign pos_dir = (axis_index_reg == 8'd0) ? DIR_RIGHT : DIR_DOWN;

    // Pick the counter that the shared unit works on
    always_comb
    begin
        sel = {1'b0, idx_reg};
        case (state_reg)
            ST_EXEC:
            begin
                if (op_reg == OP_BUTTON)
                    sel = SEL_FIRE;
                else
                    sel = {1'b0, (alu.below ? neg_dir : pos_dir)};
            end
            default:
                sel = {1'b0, idx_reg};
        endcase
    end

    assign count_mux = (sel == SEL_FIRE) ? fire_cnt_reg : hold_reg[sel[1:0]];

    jda_alu u_alu (
        .count        (count_mux),
        .repeat_start (repeat_start_reg),
        .axis_value   (axis_value_reg),
        .dead_zone    (dead_zone_reg),
        .res          (alu)
    );

    // Lowest pending direction of the press mask
    always_comb
    begin
        if (mask_reg[0])
            low_dir = DIR_UP;
        else if (mask_reg[1])
            low_dir = DIR_DOWN;
        else if (mask_reg[2])
            low_dir = DIR_LEFT;
        else
            low_dir = DIR_RIGHT;
    end

    assign mask_rest = mask_reg & (mask_reg - 4'd1);

    // Sequencer: next state, counters and output register
    always_comb
    begin
        state_next     = state_reg;
        hold_next      = hold_reg;
        fire_cnt_next  = fire_cnt_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_dir_next   = out_dir_reg;
        out_fire_next  = out_fire_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = 2'd0;
                mask_next = 4'd0;
                if (in_fire)
                begin
                    if ((s_tuser == OP_AXIS) || (s_tuser == OP_BUTTON))
                        state_next = ST_EXEC;
                    else if (s_tuser == OP_TICK)
                        state_next = ST_SCAN;
                end
            end

            ST_EXEC:
            begin
                if ((op_reg == OP_AXIS) && axis_ok)
                begin
                    if (alu.below || alu.above)
                        hold_next[sel[1:0]] = alu.inc;
                    else
                    begin
                        hold_next[neg_dir] = 8'd0;
                        hold_next[pos_dir] = 8'd0;
                    end
                end
                else if ((op_reg == OP_BUTTON) && (button_index_reg == 8'd0))
                begin
                    fire_cnt_next = button_pressed_reg ? alu.inc : 8'd0;
                end
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // test and advance one direction per cycle
                if (alu.nonzero)
                    hold_next[idx_reg] = alu.inc;
                mask_next[idx_reg] = alu.emit;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == DIR_RIGHT)
                    state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (mask_reg == 4'd0)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dir_next   = low_dir;
                    out_fire_next  = fire_flag_reg;
                    out_last_next  = (mask_rest == 4'd0);
                    mask_next      = mask_rest;
                    if (mask_rest == 4'd0)
                        state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hold_reg      <= '{default: 8'd0};
            fire_cnt_reg  <= 8'd0;
            idx_reg       <= 2'd0;
            mask_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_reg      <= hold_next;
            fire_cnt_reg  <= fire_cnt_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg    <= DEAD_ZONE_RST;
            repeat_start_reg <= REPEAT_START_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEAD_ZONE)
                dead_zone_reg <= cfg_data;
            else if (cfg_index == REG_REPEAT_START)
                repeat_start_reg <= cfg_data[7:0];
        end
    end

    // Hold the accepted item and the output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg             <= s_tuser;
            axis_index_reg     <= s_tdata[7:0];
            axis_value_reg     <= s_tdata[23:8];
            button_index_reg   <= s_tdata[31:24];
            button_pressed_reg <= s_tdata[32];
            fire_flag_reg      <= (fire_cnt_reg != 8'd0);
        end
        out_dir_reg  <= out_dir_next;
        out_fire_reg <= out_fire_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> rtl/core/jda_checker.sv
// ----------------------------------------------------------------------------
// jda_checker
// Port-level checks of the joystick direction auto-repeat block, bound to
// the top level.
// ----------------------------------------------------------------------------
module jda_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast
);
    import jda_pkg::*;

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    // An axis or button item closes the input for its update only, then reopens it
    a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tuser == OP_AXIS) || (s_tuser == OP_BUTTON))
            |=> !s_tready ##1 s_tready)
        else $error("event item did not finish in one update cycle");

    // A frame tick keeps the input closed through all four direction scans
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_TICK)
            |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input opened during the direction scan");

    // Direction field stays inside its two bits
    a_dir_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding bits not zero");

endmodule

bind joystick_direction_autorepeat_top jda_checker u_jda_checker (.*);
